FILE: hw/rtl/length_prefixed_deframer_macros.svh
// assertion macros for the length prefixed deframer
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
// check that is off while reset is asserted
`define LPD_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// check that also runs through reset
`define LPD_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define LPD_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define LPD_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

FILE: hw/rtl/lpd_pkg.sv
// shared constants and types for the length prefixed deframer
// no dependencies; used by lpd_step and length_prefixed_deframer
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

	localparam int unsigned HeaderSize = 17;
	localparam int unsigned IdBytes    = 8;

	typedef logic [4:0] hpos_t;

	localparam hpos_t PosVersion = hpos_t'(0);
	localparam hpos_t PosCommand = hpos_t'(1);
	localparam hpos_t PosLenHi   = hpos_t'(2);
	localparam hpos_t PosLenLo   = hpos_t'(3);
	localparam hpos_t PosDevType = hpos_t'(4);
	localparam hpos_t PosIdLast  = hpos_t'(5 + IdBytes - 1);
	localparam hpos_t PosSeqLast = hpos_t'(HeaderSize - 1);
	localparam hpos_t HdrDone    = hpos_t'(HeaderSize);

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic [15:0] packet_length;
		logic [7:0]  version;
		logic [7:0]  command;
		logic [7:0]  device_type;
		logic [63:0] device_id;
		logic [31:0] sequence_res;
		logic        last_of_packet;
		logic        header_only;
		logic        truncated;
		logic [15:0] packet_number;
	} result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/length_prefixed_deframer.sv
// Length prefixed deframer, top level.
// Input channel: one buffer byte per item (data_byte, end_of_buffer), in_valid/in_stall.
// Output channel: one tagged payload byte, header-only or truncated item per
// out_valid/out_stall transfer, with the captured header fields alongside.
// Each packet is a 17-byte header (version, command, big-endian length, device
// type, 8-byte id, 4-byte sequence) then length payload bytes. Header bytes
// give no item, except the final one of a zero-length packet. A buffer that
// ends mid-packet gives one truncated item in place of its last byte's item.
// Path: input register, step logic with header state, result register; out_valid
// and the result fields come from the result register.
// Throughput: one byte item per cycle unless the output stalls; the header/payload
// counters update on every accepted byte, so items flow back to back.
// Stalls: out_stall holds the result register; the input register then fills
// and in_stall rises until the result is taken.
// Reset: arst_n clears both registers' valid bits and all header state.
// Uses lpd_pkg, lpd_step and length_prefixed_deframer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "length_prefixed_deframer_macros.svh"

module length_prefixed_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_buffer,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       payload_byte,
	output logic [15:0]      byte_index,
	output logic [15:0]      packet_length,
	output logic [7:0]       version,
	output logic [7:0]       command,
	output logic [7:0]       device_type,
	output logic [63:0]      device_id,
	output logic [31:0]      sequence_res,
	output logic             last_of_packet,
	output logic             header_only,
	output logic             truncated,
	output logic [15:0]      packet_number
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              eob_s1;
	logic              out_valid_q;
	lpd_pkg::result_t  result_q;
	lpd_pkg::result_t  step_res;
	logic              step_valid;
	logic              out_free;
	logic              fire;

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	lpd_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data      (data_s1),
		.eob       (eob_s1),
		.res       (step_res),
		.res_valid (step_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= step_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_valid) begin
			result_q <= step_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign payload_byte   = result_q.payload_byte;
	assign byte_index     = result_q.byte_index;
	assign packet_length  = result_q.packet_length;
	assign version        = result_q.version;
	assign command        = result_q.command;
	assign device_type    = result_q.device_type;
	assign device_id      = result_q.device_id;
	assign sequence_res   = result_q.sequence_res;
	assign last_of_packet = result_q.last_of_packet;
	assign header_only    = result_q.header_only;
	assign truncated      = result_q.truncated;
	assign packet_number  = result_q.packet_number;

	`LPD_ASSERT(a_stall_only_on_full, clk, arst_n, in_stall |-> (out_valid && out_stall), "input stalled while result register can move")
	`LPD_ASSERT(a_flags_exclusive, clk, arst_n, out_valid |-> !(truncated && (last_of_packet || header_only)), "truncated item also marked as packet end")
	`LPD_ASSERT(a_hdr_only_is_last, clk, arst_n, (out_valid && header_only) |-> (last_of_packet && (payload_byte == 8'd0) && (packet_length == 16'd0)), "header-only item malformed")
	`LPD_ASSERT_ALWAYS(a_reset_empty, clk, ($past(arst_n) == 1'b0) |-> !out_valid, "result valid right after reset")

endmodule

`default_nettype wire

FILE: hw/rtl/lpd_step.sv
// header capture and payload tagging state for the length prefixed deframer
// one byte item per fire; uses lpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpd_step (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire logic [7:0]      data,
	input  wire logic            eob,
	output lpd_pkg::result_t     res,
	output logic                 res_valid
);

	lpd_pkg::hpos_t hpos_q;
	logic [15:0] pcount_q;
	logic [7:0]  ver_q, cmd_q, dtype_q;
	logic [15:0] len_q;
	logic [63:0] id_q;
	logic [31:0] seq_q;
	logic [15:0] seen_q;

	logic [7:0]  ver_n, cmd_n, dtype_n;
	logic [15:0] len_n;
	logic [63:0] id_n;
	logic [31:0] seq_n;

	logic        payload_mode;
	logic        last;
	logic        trunc;
	logic [15:0] pcount_inc;
	logic [15:0] seen_inc;

	always_comb begin
		payload_mode = (hpos_q == lpd_pkg::HdrDone);
		pcount_inc   = pcount_q + 16'd1;
		seen_inc     = (seen_q == 16'hFFFF) ? seen_q : seen_q + 16'd1;

		ver_n   = ver_q;
		cmd_n   = cmd_q;
		len_n   = len_q;
		dtype_n = dtype_q;
		id_n    = id_q;
		seq_n   = seq_q;
		if (!payload_mode) begin
			priority if (hpos_q == lpd_pkg::PosVersion) begin
				ver_n   = data;
				cmd_n   = '0;
				len_n   = '0;
				dtype_n = '0;
				id_n    = '0;
				seq_n   = '0;
			end else if (hpos_q == lpd_pkg::PosCommand) begin
				cmd_n = data;
			end else if (hpos_q == lpd_pkg::PosLenHi) begin
				len_n = {data, 8'h00};
			end else if (hpos_q == lpd_pkg::PosLenLo) begin
				len_n = {len_q[15:8], data};
			end else if (hpos_q == lpd_pkg::PosDevType) begin
				dtype_n = data;
			end else if (hpos_q <= lpd_pkg::PosIdLast) begin
				id_n = {id_q[55:0], data};
			end else begin
				seq_n = {seq_q[23:0], data};
			end
		end

		// length is complete well before the final header byte
		last  = payload_mode ? (pcount_inc == len_q)
			: ((hpos_q == lpd_pkg::PosSeqLast) && (len_q == 16'd0));
		trunc = eob && !last;

		res_valid = fire && (payload_mode || last || eob);

		res.payload_byte   = (payload_mode && !trunc) ? data : 8'd0;
		res.byte_index     = (payload_mode && !trunc) ? pcount_q : 16'd0;
		res.packet_length  = len_n;
		res.version        = ver_n;
		res.command        = cmd_n;
		res.device_type    = dtype_n;
		res.device_id      = id_n;
		res.sequence_res   = seq_n;
		res.last_of_packet = last;
		res.header_only    = last && !payload_mode;
		res.truncated      = trunc;
		res.packet_number  = last ? seen_inc : seen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q   <= lpd_pkg::PosVersion;
			pcount_q <= '0;
			ver_q    <= '0;
			cmd_q    <= '0;
			len_q    <= '0;
			dtype_q  <= '0;
			id_q     <= '0;
			seq_q    <= '0;
			seen_q   <= '0;
		end else if (fire) begin
			ver_q   <= ver_n;
			cmd_q   <= cmd_n;
			len_q   <= len_n;
			dtype_q <= dtype_n;
			id_q    <= id_n;
			seq_q   <= seq_n;
			if (last || trunc) begin
				hpos_q   <= lpd_pkg::PosVersion;
				pcount_q <= '0;
			end else if (payload_mode) begin
				pcount_q <= pcount_inc;
			end else begin
				hpos_q <= hpos_q + 5'd1;
			end
			if (eob) begin
				seen_q <= '0;
			end else if (last) begin
				seen_q <= seen_inc;
			end
		end
	end

endmodule

`default_nettype wire

FILE: test/tb.sv
// self-checking testbench for length_prefixed_deframer: byte stream in, tagged results out
// a built-in deframer predictor queues expected items, each result is checked in order
// depends on lpd_pkg and the length_prefixed_deframer rtl
`timescale 1ns / 1ps

module tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_buffer = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  payload_byte;
	logic [15:0] byte_index;
	logic [15:0] packet_length;
	logic [7:0]  version;
	logic [7:0]  command;
	logic [7:0]  device_type;
	logic [63:0] device_id;
	logic [31:0] sequence_res;
	logic        last_of_packet;
	logic        header_only;
	logic        truncated;
	logic [15:0] packet_number;

	length_prefixed_deframer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.end_of_buffer  (end_of_buffer),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.payload_byte   (payload_byte),
		.byte_index     (byte_index),
		.packet_length  (packet_length),
		.version        (version),
		.command        (command),
		.device_type    (device_type),
		.device_id      (device_id),
		.sequence_res   (sequence_res),
		.last_of_packet (last_of_packet),
		.header_only    (header_only),
		.truncated      (truncated),
		.packet_number  (packet_number)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	lpd_pkg::hpos_t hdr_pos = '0;
	logic [15:0] pay_cnt = '0;
	logic [7:0]  cur_version = '0;
	logic [7:0]  cur_command = '0;
	logic [15:0] cur_length = '0;
	logic [7:0]  cur_dev_type = '0;
	logic [63:0] cur_dev_id = '0;
	logic [31:0] cur_seq = '0;
	logic [15:0] buf_pkt_count = '0;

	lpd_pkg::result_t pending_results[$];
	lpd_pkg::result_t seen_result;
	lpd_pkg::result_t want_result;

	int          bytes_sent = 0;
	int          results_checked = 0;
	int          packets_done = 0;
	int          fail_count = 0;
	int          shown = 0;
	bit          tx_idle = 1'b0;
	bit          rx_idle = 1'b0;
	int          hold_request = 0;
	int          stall_left = 0;

	function automatic string fmt_result(lpd_pkg::result_t r);
		return $sformatf("byte=%h idx=%0d len=%0d ver=%h cmd=%h dtype=%h id=%h seq=%h %s%b %s%b %s%b num=%0d",
			r.payload_byte, r.byte_index, r.packet_length, r.version, r.command,
			r.device_type, r.device_id, r.sequence_res, "last=", r.last_of_packet,
			"hdr=", r.header_only, "trunc=", r.truncated, r.packet_number);
	endfunction

	// advance the deframer state by one buffer byte and queue the item it yields
	task automatic deframe_byte(input logic [7:0] b, input logic eob);
		logic        have;
		logic        last;
		logic        hdr_only;
		logic        trunc;
		logic [7:0]  pb;
		logic [15:0] idx;
		have = 1'b0;
		last = 1'b0;
		hdr_only = 1'b0;
		pb = 8'h00;
		idx = 16'h0000;
		if (hdr_pos >= lpd_pkg::HdrDone) begin
			pb = b;
			idx = pay_cnt;
			pay_cnt = pay_cnt + 16'd1;
			have = 1'b1;
			if (pay_cnt == cur_length)
				last = 1'b1;
		end else begin
			if (hdr_pos == lpd_pkg::PosVersion) begin
				cur_version = b;
				cur_command = '0;
				cur_length = '0;
				cur_dev_type = '0;
				cur_dev_id = '0;
				cur_seq = '0;
			end else if (hdr_pos == lpd_pkg::PosCommand) begin
				cur_command = b;
			end else if (hdr_pos == lpd_pkg::PosLenHi) begin
				cur_length = {b, 8'h00};
			end else if (hdr_pos == lpd_pkg::PosLenLo) begin
				cur_length = cur_length | {8'h00, b};
			end else if (hdr_pos == lpd_pkg::PosDevType) begin
				cur_dev_type = b;
			end else if (hdr_pos <= lpd_pkg::PosIdLast) begin
				cur_dev_id = {cur_dev_id[55:0], b};
			end else begin
				cur_seq = {cur_seq[23:0], b};
			end
			hdr_pos = hdr_pos + 5'd1;
			if (hdr_pos >= lpd_pkg::HdrDone && cur_length == 16'h0000) begin
				have = 1'b1;
				last = 1'b1;
				hdr_only = 1'b1;
			end
		end
		if (last) begin
			if (buf_pkt_count != 16'hFFFF)
				buf_pkt_count = buf_pkt_count + 16'd1;
			hdr_pos = '0;
			pay_cnt = '0;
		end
		trunc = eob && !last;
		if (trunc) begin
			pb = 8'h00;
			idx = 16'h0000;
			have = 1'b1;
			hdr_pos = '0;
			pay_cnt = '0;
		end
		if (have) begin
			pending_results.push_back({pb, idx, cur_length, cur_version, cur_command,
				cur_dev_type, cur_dev_id, cur_seq, last, hdr_only, trunc, buf_pkt_count});
			if (last)
				packets_done++;
		end
		if (eob)
			buf_pkt_count = '0;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic eob);
		if (tx_idle && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_buffer <= eob;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		deframe_byte(b, eob);
		bytes_sent++;
		@(negedge clk);
	endtask

	// send the first count bytes of a packet, flagging the last one sent as buffer end if eob_at_end
	task automatic send_frame(input logic [7:0] ver, input logic [7:0] cmd,
			input logic [15:0] len, input logic [7:0] dtype, input logic [63:0] id,
			input logic [31:0] seq_num, input int count, input bit eob_at_end);
		logic [7:0] b;
		for (int k = 0; k < count; k++) begin
			if (k == lpd_pkg::PosVersion)
				b = ver;
			else if (k == lpd_pkg::PosCommand)
				b = cmd;
			else if (k == lpd_pkg::PosLenHi)
				b = len[15:8];
			else if (k == lpd_pkg::PosLenLo)
				b = len[7:0];
			else if (k == lpd_pkg::PosDevType)
				b = dtype;
			else if (k <= int'(lpd_pkg::PosIdLast))
				b = id[8 * (int'(lpd_pkg::PosIdLast) - k) +: 8];
			else if (k < lpd_pkg::HeaderSize)
				b = seq_num[8 * (int'(lpd_pkg::PosSeqLast) - k) +: 8];
			else
				b = 8'($urandom_range(0, 255));
			send_byte(b, eob_at_end && k == count - 1);
		end
	endtask

	task automatic send_random_frame(input int max_len, input bit eob_at_end, input bit cut);
		logic [15:0] len;
		logic [63:0] id;
		int          count;
		len = 16'($urandom_range(0, max_len));
		id = ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom};
		count = cut ? $urandom_range(1, lpd_pkg::HeaderSize + len)
			: lpd_pkg::HeaderSize + len;
		send_frame(8'($urandom), 8'($urandom), len, 8'($urandom), id, $urandom, count,
			eob_at_end);
	endtask

	task automatic wait_drained;
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_header_fields;
		send_frame(8'hFF, 8'hFF, 16'h0000, 8'hFF, '1, '1, lpd_pkg::HeaderSize, 1'b0);
		send_frame(8'h00, 8'h00, 16'h0000, 8'h00, '0, '0, lpd_pkg::HeaderSize, 1'b0);
		send_frame(8'hA5, 8'h3C, 16'h0001, 8'h5A, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF,
			lpd_pkg::HeaderSize + 1, 1'b1);
		send_frame(8'h5A, 8'hC3, 16'h0000, 8'hA5, 64'hFEDC_BA98_7654_3210, 32'h1357_9BDF,
			lpd_pkg::HeaderSize, 1'b1);
	endtask

	task automatic test_truncation;
		send_frame(8'h11, 8'h22, 16'hFFFF, 8'h33, 64'h8000_0000_0000_0001, 32'h8000_0001,
			lpd_pkg::HeaderSize + 3, 1'b1);
		send_frame(8'h7E, 8'h81, 16'h0100, 8'h44, '1, '1, 1, 1'b1);
		send_frame(8'h81, 8'h7E, 16'h0100, 8'h55, '1, '1, 3, 1'b1);
		send_frame(8'h01, 8'h02, 16'h0004, 8'h66, 64'hAAAA_5555_AAAA_5555, '0, 10, 1'b1);
		send_frame(8'h03, 8'h04, 16'h0002, 8'h77, '0, 32'h5555_AAAA,
			lpd_pkg::HeaderSize + 1, 1'b1);
	endtask

	task automatic test_backpressure;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_request = 300;
		repeat (3)
			send_random_frame(8, 1'b0, 1'b0);
		send_random_frame(8, 1'b1, 1'b0);
	endtask

	task automatic test_pause;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_random_frame(6, 1'b0, 1'b0);
		send_random_frame(6, 1'b1, 1'b0);
		wait_drained();
		send_random_frame(6, 1'b0, 1'b0);
		send_random_frame(6, 1'b1, 1'b0);
	endtask

	task automatic test_random;
		int start;
		int pick;
		start = bytes_sent;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		while (bytes_sent - start < 80) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// noise, always closed by a buffer end to realign
				repeat ($urandom_range(0, 20))
					send_byte(8'($urandom), 1'($urandom_range(0, 7) == 0));
				send_byte(8'($urandom), 1'b1);
			end else if (pick == 1) begin
				send_random_frame(8, 1'b1, 1'b1);
			end else if (pick == 2) begin
				send_random_frame(40, $urandom_range(0, 3) == 0, 1'b0);
			end else begin
				send_random_frame(8, $urandom_range(0, 3) == 0, 1'b0);
			end
		end
		send_random_frame(4, 1'b1, 1'b0);
	endtask

	task automatic test_back_to_back;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (2)
			send_random_frame(8, 1'b0, 1'b0);
		send_random_frame(8, 1'b1, 1'b0);
	endtask

	// receiver stall: random bursts, or one long hold when requested
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (hold_request != 0) begin
					stall_left = hold_request;
					hold_request = 0;
				end else if (rx_idle && $urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(1, 18);
				end
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_result = {payload_byte, byte_index, packet_length, version, command,
				device_type, device_id, sequence_res, last_of_packet, header_only,
				truncated, packet_number};
			if (pending_results.size() == 0) begin
				fail_count++;
				if (shown < 10) begin
					shown++;
					$display("unexpected item: %s", fmt_result(seen_result));
				end
			end else begin
				want_result = pending_results.pop_front();
				results_checked++;
				if (seen_result !== want_result) begin
					fail_count++;
					if (shown < 10) begin
						shown++;
						$display("mismatch at result %0d", results_checked);
						$display("  expected %s", fmt_result(want_result));
						$display("  actual   %s", fmt_result(seen_result));
					end
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("FAIL length_prefixed_deframer");
		$finish;
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_header_fields();
		test_truncation();
		test_backpressure();
		test_pause();
		test_random();
		test_back_to_back();
		wait_drained();
		repeat (20) @(negedge clk);
		if (pending_results.size() != 0) begin
			fail_count += pending_results.size();
			$display("%0d expected items never arrived", pending_results.size());
		end
		$display("sent %0d bytes, checked %0d items, %0d complete packets", bytes_sent,
			results_checked, packets_done);
		$display("covered header-only, truncated, noisy and back-pressured buffers");
		if (fail_count == 0)
			$display("PASS length_prefixed_deframer");
		else
			$display("FAIL length_prefixed_deframer");
		$finish;
	end

endmodule
